FILE: sv/drcg_pkg.sv
// ----------------------------------------------------------------------------
// drcg_pkg
// Types and constants shared by the drop-rate compression governor modules.
// ----------------------------------------------------------------------------
package drcg_pkg;

  localparam int unsigned RING_DEPTH = 3;
  localparam int unsigned SLOT_W     = 2;

  typedef enum logic [2:0] {
    CFG_CHECK_INTERVAL  = 3'd0,
    CFG_RAISE_THR_ZERO  = 3'd1,
    CFG_RAISE_THR_ONE   = 3'd2,
    CFG_RAISE_THR_TWO   = 3'd3,
    CFG_RAISE_THR_THREE = 3'd4,
    CFG_LOWEST_FLOOR    = 3'd5
  } cfg_idx_t;

  localparam logic [2:0] LVL_0 = 3'd0;
  localparam logic [2:0] LVL_1 = 3'd1;
  localparam logic [2:0] LVL_2 = 3'd2;
  localparam logic [2:0] LVL_3 = 3'd3;
  localparam logic [2:0] LVL_4 = 3'd4;

  typedef struct packed {
    logic [31:0] sample_index;
    logic [15:0] payload_bytes;
    logic [2:0]  level_now;
  } item_t;

  typedef struct packed {
    logic [31:0] check_interval;
    logic [23:0] raise_thr_zero;
    logic [23:0] raise_thr_one;
    logic [23:0] raise_thr_two;
    logic [23:0] raise_thr_three;
    logic [15:0] lowest_floor;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] level;
    logic       ring_filled;
  } core_stat_t;

  localparam cfg_t CFG_RESET = '{
    check_interval:  32'd32896,
    raise_thr_zero:  24'd5000,
    raise_thr_one:   24'd15000,
    raise_thr_two:   24'd30000,
    raise_thr_three: 24'd40000,
    lowest_floor:    16'd20
  };

endpackage

FILE: sv/drcg_cfg_regs.sv
// ----------------------------------------------------------------------------
// drcg_cfg_regs
// Configuration register file: threshold, interval and floor registers, write only.
// ----------------------------------------------------------------------------
module drcg_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output drcg_pkg::cfg_t cfg
);
  import drcg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHECK_INTERVAL:  cfg_nxt.check_interval  = cfg_wdata;
        CFG_RAISE_THR_ZERO:  cfg_nxt.raise_thr_zero  = cfg_wdata[23:0];
        CFG_RAISE_THR_ONE:   cfg_nxt.raise_thr_one   = cfg_wdata[23:0];
        CFG_RAISE_THR_TWO:   cfg_nxt.raise_thr_two   = cfg_wdata[23:0];
        CFG_RAISE_THR_THREE: cfg_nxt.raise_thr_three = cfg_wdata[23:0];
        CFG_LOWEST_FLOOR:    cfg_nxt.lowest_floor    = cfg_wdata[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/drcg_in_stage.sv
// ----------------------------------------------------------------------------
// drcg_in_stage
// Input register for one packet header, with valid/stall handshake.
// ----------------------------------------------------------------------------
module drcg_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  drcg_pkg::item_t item_in,
  input  logic            advance,
  output logic            s1_valid,
  output drcg_pkg::item_t item
);
  import drcg_pkg::*;

  logic  s1_valid_r;
  item_t item_r;

  assign in_stall = s1_valid_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= item_in;
    end
  end

  assign s1_valid = s1_valid_r;
  assign item     = item_r;

endmodule

FILE: sv/drcg_core.sv
// ----------------------------------------------------------------------------
// drcg_core
// Governor state and single-pass update: index/byte tracking, shortfall ring,
// threshold compare and level choice.
// ----------------------------------------------------------------------------
module drcg_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  drcg_pkg::item_t      item,
  input  drcg_pkg::cfg_t       cfg,
  output drcg_pkg::core_stat_t stat
);
  import drcg_pkg::*;

  logic [31:0]       highest_r, highest_nxt;
  logic [31:0]       bytes_total_r, bytes_total_nxt;
  logic [31:0]       check_point_r;
  logic [31:0]       bytes_at_check_r;
  logic [31:0]       ring_r   [RING_DEPTH];
  logic [31:0]       ring_nxt [RING_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              filled_r, filled_nxt;

  logic [31:0] limit;
  logic        check;
  logic [31:0] diff, diff3, expected, actual, shortfall, sum;
  logic [25:0] thr0_x3, thr1_x3, thr2_x3, thr3_x3;
  logic [17:0] floor_x3;
  logic [2:0]  lvl, req;

  assign lvl = item.level_now;

  assign highest_nxt     = (item.sample_index > highest_r) ? item.sample_index : highest_r;
  assign bytes_total_nxt = bytes_total_r + {16'd0, item.payload_bytes};
  assign limit           = check_point_r + cfg.check_interval;
  assign check           = limit < item.sample_index;

  assign diff  = highest_nxt - check_point_r;
  assign diff3 = diff + {diff[30:0], 1'b0};

  always_comb begin
    case (lvl)
      LVL_0:   expected = {diff[29:0], 2'b00};
      LVL_1:   expected = {diff[30:0], 1'b0};
      LVL_2:   expected = diff3;
      LVL_3:   expected = {1'b0, diff3[31:1]};
      LVL_4:   expected = {1'b0, diff[31:1]};
      default: expected = 32'd0;
    endcase
  end

  assign actual    = bytes_total_nxt - bytes_at_check_r;
  assign shortfall = (actual > expected) ? 32'd0 : expected - actual;

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_nxt[i] = (slot_r == SLOT_W'(i)) ? shortfall : ring_r[i];
    end
  end

  assign sum = ring_nxt[0] + ring_nxt[1] + ring_nxt[2];

  assign slot_nxt   = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign filled_nxt = filled_r | (slot_r == SLOT_W'(RING_DEPTH - 1));

  assign thr0_x3  = {2'b00, cfg.raise_thr_zero}  + {1'b0, cfg.raise_thr_zero, 1'b0};
  assign thr1_x3  = {2'b00, cfg.raise_thr_one}   + {1'b0, cfg.raise_thr_one, 1'b0};
  assign thr2_x3  = {2'b00, cfg.raise_thr_two}   + {1'b0, cfg.raise_thr_two, 1'b0};
  assign thr3_x3  = {2'b00, cfg.raise_thr_three} + {1'b0, cfg.raise_thr_three, 1'b0};
  assign floor_x3 = {2'b00, cfg.lowest_floor}    + {1'b0, cfg.lowest_floor, 1'b0};

  always_comb begin
    if (lvl == LVL_0 && sum > {6'd0, thr0_x3}) begin
      req = LVL_1;
    end else if (lvl == LVL_1 && sum > {6'd0, thr1_x3}) begin
      req = LVL_2;
    end else if (lvl == LVL_2 && sum > {6'd0, thr2_x3}) begin
      req = LVL_3;
    end else if (lvl == LVL_3 && sum > {6'd0, thr3_x3}) begin
      req = LVL_4;
    end else if (lvl == LVL_4 && sum < {6'd0, thr2_x3}) begin
      req = LVL_3;
    end else if (lvl == LVL_3 && sum < {6'd0, thr1_x3}) begin
      req = LVL_2;
    end else if (lvl == LVL_2 && sum < {6'd0, thr0_x3}) begin
      req = LVL_1;
    end else if (lvl == LVL_1 && sum < {14'd0, floor_x3}) begin
      req = LVL_0;
    end else begin
      req = lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r        <= '0;
      bytes_total_r    <= '0;
      check_point_r    <= '0;
      bytes_at_check_r <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      slot_r   <= '0;
      filled_r <= 1'b0;
    end else if (fire) begin
      highest_r     <= highest_nxt;
      bytes_total_r <= bytes_total_nxt;
      if (check) begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_r[i] <= ring_nxt[i];
        end
        slot_r           <= slot_nxt;
        filled_r         <= filled_nxt;
        bytes_at_check_r <= bytes_total_nxt;
        check_point_r    <= highest_nxt;
      end
    end
  end

  assign stat.emit        = check & (req != lvl) & filled_nxt;
  assign stat.level       = req;
  assign stat.ring_filled = filled_r;

endmodule

FILE: sv/drop_rate_compression_governor.sv
// ----------------------------------------------------------------------------
// drop_rate_compression_governor
// Watches received audio packet headers and requests a new compression level
// when the averaged byte shortfall crosses the configured thresholds.
//
// Input channel (in_valid/in_stall) carries one packet header per transfer:
// sample index, payload byte count and the packet's compression level.
// Output channel (out_valid/out_stall) carries a requested level; a header
// yields at most one request, most yield none.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 check
// interval, 1..4 raise thresholds, 5 lowest floor); write only while idle.
// Throughput: one header per cycle while the receiver does not stall. The
// request path runs from the input register through the core's state update
// into the result register that drives out_valid.
// Reset (rst_n low, synchronous) clears all tracking state and the ring and
// restores the default register values.
// When the receiver stalls, the pending request holds in the result register
// and at most one more header is taken into the input register, if it is
// empty; after that in_stall rises until the request is transferred.
// ----------------------------------------------------------------------------
module drop_rate_compression_governor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_index,
  input  logic [15:0] in_payload_bytes,
  input  logic [2:0]  in_level_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_requested_level,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import drcg_pkg::*;

  cfg_t       cfg;
  item_t      item_in, item;
  core_stat_t stat;
  logic       s1_valid;
  logic       advance;
  logic       fire;
  logic       out_valid_r;
  logic [2:0] out_level_r;

  assign item_in.sample_index  = in_sample_index;
  assign item_in.payload_bytes = in_payload_bytes;
  assign item_in.level_now     = in_level_now;

  assign advance = ~out_valid_r | ~out_stall;
  assign fire    = s1_valid & advance;

  drcg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  drcg_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_in  (item_in),
    .advance  (advance),
    .s1_valid (s1_valid),
    .item     (item)
  );

  drcg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire & stat.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stat.emit) begin
      out_level_r <= stat.level;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_requested_level = out_level_r;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= LVL_4)
    else $error("requested level out of range");

  a_ring_filled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> stat.ring_filled)
    else $error("request issued before ring filled");

  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid))
    else $error("request without a header in the input register");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && out_valid_r)
    else $error("input stalled with free pipeline");

endmodule
